[hdl/brr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brr_pkg: shared definitions of the bit reservoir reader
// Store geometry, read limits, command and error codes, sequencer states and
// the structs that pass between the blocks.
// ---------------------------------------------------------------------------
package brr_pkg;

  localparam int STORE_DEPTH   = 4096;
  localparam int MAX_READ_BITS = 32;
  localparam int BYTE_BITS     = 8;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = 12;
  localparam int WORD_W  = 32;
  localparam int LEFT_W  = 4;
  localparam int J_W     = $clog2(MAX_READ_BITS + 1);

  typedef enum logic [1:0] {
    CMD_PUT          = 2'd0,
    CMD_GET          = 2'd1,
    CMD_REWIND_BITS  = 2'd2,
    CMD_REWIND_BYTES = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNDERRUN = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] consumed;
    err_t              error;
  } result_t;

endpackage

[hdl/brr_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brr_if: item channels of the bit reservoir reader
// Command channel into the block and result channel out of it, each with a
// valid/ready handshake.
// ---------------------------------------------------------------------------
interface brr_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [7:0]                data_byte;
  logic [brr_pkg::CNT_W-1:0] count;

  modport source (output valid, output cmd, output data_byte, output count, input ready);
  modport sink   (input valid, input cmd, input data_byte, input count, output ready);
endinterface

interface brr_out_if;
  logic                       valid;
  logic                       ready;
  logic [brr_pkg::WORD_W-1:0] read_value;
  logic [brr_pkg::WORD_W-1:0] bits_consumed;
  logic [1:0]                 error;

  modport source (output valid, output read_value, output bits_consumed, output error,
                  input ready);
  modport sink   (input valid, input read_value, input bits_consumed, input error,
                  output ready);
endinterface

[hdl/brr_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brr_store: circular byte store
// Single-port synchronous RAM with a registered read, one access per cycle.
// ---------------------------------------------------------------------------
module brr_store (
  input  logic              clk,
  input  brr_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [brr_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data_r <= mem[req.addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/brr_outbuf.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brr_outbuf: result holding register
// Keeps one finished result until the downstream side takes it.
// ---------------------------------------------------------------------------
module brr_outbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  brr_pkg::result_t res,
  output logic             free,
  brr_out_if.source        out_ch
);

  logic                       valid_r;
  logic [brr_pkg::WORD_W-1:0] value_r;
  logic [brr_pkg::WORD_W-1:0] consumed_r;
  brr_pkg::err_t              error_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      value_r    <= res.value;
      consumed_r <= res.consumed;
      error_r    <= res.error;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.read_value    = value_r;
  assign out_ch.bits_consumed = consumed_r;
  assign out_ch.error         = error_r;

endmodule

[hdl/brr_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brr_seq: command sequencer and bit extraction datapath
// Holds the read and write positions, walks a read over the stored bytes one
// memory read at a time and builds the result.
// ---------------------------------------------------------------------------
module brr_seq (
  input  logic               clk,
  input  logic               rst_n,
  brr_in_if.sink             in_ch,
  output brr_pkg::mem_req_t  mem_req,
  input  logic [7:0]         rd_data,
  input  logic               out_free,
  output brr_pkg::result_t   res
);

  localparam int AW = brr_pkg::ADDR_W;
  localparam int WW = brr_pkg::WORD_W;
  localparam int LW = brr_pkg::LEFT_W;
  localparam int JW = brr_pkg::J_W;
  localparam int CW = brr_pkg::CNT_W;

  brr_pkg::state_t state_r, state_nxt;
  brr_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [7:0]      data_r, data_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic [WW-1:0] wc_r, wc_nxt;
  logic [WW-1:0] rbi_r, rbi_nxt;
  logic [LW-1:0] bl_r, bl_nxt;
  logic [WW-1:0] total_r, total_nxt;

  logic [WW-1:0] widx_r, widx_nxt;
  logic [LW-1:0] wleft_r, wleft_nxt;
  logic [JW-1:0] wj_r, wj_nxt;
  logic [WW-1:0] acc_r, acc_nxt;

  logic [WW-1:0]   res_value_r, res_value_nxt;
  brr_pkg::err_t   res_err_r, res_err_nxt;

  logic [CW:0]   rw_bits;
  logic [WW-1:0] first_idx;
  logic [LW-1:0] first_left;
  logic [LW-1:0] take;
  logic [7:0]    byte_mask;
  logic [7:0]    piece;
  logic [WW-1:0] acc_new;
  logic [LW-1:0] left_new;
  logic [JW-1:0] j_new;
  logic [WW-1:0] next_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brr_pkg::S_IDLE;
      wc_r    <= '0;
      rbi_r   <= '0;
      bl_r    <= LW'(brr_pkg::BYTE_BITS);
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      wc_r    <= wc_nxt;
      rbi_r   <= rbi_nxt;
      bl_r    <= bl_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    data_r      <= data_nxt;
    count_r     <= count_nxt;
    widx_r      <= widx_nxt;
    wleft_r     <= wleft_nxt;
    wj_r        <= wj_nxt;
    acc_r       <= acc_nxt;
    res_value_r <= res_value_nxt;
    res_err_r   <= res_err_nxt;
  end

  // Datapath pieces used by the sequencer below.
  always_comb begin
    rw_bits    = {{(CW + 1 - LW){1'b0}}, bl_r} + {1'b0, count_r};
    first_idx  = (bl_r == '0) ? rbi_r + WW'(1) : rbi_r;
    first_left = (bl_r == '0) ? LW'(brr_pkg::BYTE_BITS) : bl_r;
    take       = (wj_r < JW'(wleft_r)) ? wj_r[LW-1:0] : wleft_r;
    byte_mask  = 8'hFF >> (LW'(brr_pkg::BYTE_BITS) - wleft_r);
    piece      = (rd_data & byte_mask) >> (wleft_r - take);
    acc_new    = (acc_r << take) | WW'(piece);
    left_new   = wleft_r - take;
    j_new      = wj_r - JW'(take);
    next_idx   = widx_r + WW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    data_nxt      = data_r;
    count_nxt     = count_r;
    wc_nxt        = wc_r;
    rbi_nxt       = rbi_r;
    bl_nxt        = bl_r;
    total_nxt     = total_r;
    widx_nxt      = widx_r;
    wleft_nxt     = wleft_r;
    wj_nxt        = wj_r;
    acc_nxt       = acc_r;
    res_value_nxt = res_value_r;
    res_err_nxt   = res_err_r;
    in_ch.ready   = 1'b0;
    mem_req.wr_en = 1'b0;
    mem_req.addr  = widx_r[AW-1:0];
    mem_req.wdata = data_r;
    res.valid     = 1'b0;
    res.value     = res_value_r;
    res.consumed  = total_r;
    res.error     = res_err_r;

    unique case (state_r)
      brr_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt   = brr_pkg::cmd_t'(in_ch.cmd);
          data_nxt  = in_ch.data_byte;
          count_nxt = in_ch.count;
          state_nxt = brr_pkg::S_EXEC;
        end
      end

      brr_pkg::S_EXEC: begin
        res_value_nxt = '0;
        res_err_nxt   = brr_pkg::ERR_NONE;
        state_nxt     = brr_pkg::S_DONE;
        unique case (cmd_r)
          brr_pkg::CMD_PUT: begin
            mem_req.wr_en = 1'b1;
            mem_req.addr  = wc_r[AW-1:0];
            wc_nxt        = wc_r + WW'(1);
          end
          brr_pkg::CMD_REWIND_BITS: begin
            // Eight bits left in a byte folds to zero left in the byte before.
            total_nxt = total_r - WW'(count_r);
            rbi_nxt   = rbi_r - WW'(rw_bits[CW:3]);
            bl_nxt    = LW'(rw_bits[2:0]);
          end
          brr_pkg::CMD_REWIND_BYTES: begin
            total_nxt = total_r - WW'({count_r, 3'b000});
            rbi_nxt   = rbi_r - WW'(count_r);
          end
          brr_pkg::CMD_GET: begin
            if (count_r > CW'(brr_pkg::MAX_READ_BITS)) begin
              res_err_nxt = brr_pkg::ERR_TOO_LONG;
            end else if (count_r != '0) begin
              if (first_idx >= wc_r) begin
                res_err_nxt = brr_pkg::ERR_UNDERRUN;
              end else begin
                mem_req.addr = first_idx[AW-1:0];
                widx_nxt     = first_idx;
                wleft_nxt    = first_left;
                wj_nxt       = JW'(count_r);
                acc_nxt      = '0;
                state_nxt    = brr_pkg::S_DATA;
              end
            end
          end
          default: begin
          end
        endcase
      end

      brr_pkg::S_DATA: begin
        if (j_new == '0) begin
          rbi_nxt       = widx_r;
          bl_nxt        = left_new;
          total_nxt     = total_r + WW'(count_r);
          res_value_nxt = acc_new;
          res_err_nxt   = brr_pkg::ERR_NONE;
          state_nxt     = brr_pkg::S_DONE;
        end else if (next_idx >= wc_r) begin
          // The read is abandoned and the positions stay as they were.
          res_value_nxt = '0;
          res_err_nxt   = brr_pkg::ERR_UNDERRUN;
          state_nxt     = brr_pkg::S_DONE;
        end else begin
          mem_req.addr = next_idx[AW-1:0];
          widx_nxt     = next_idx;
          wleft_nxt    = LW'(brr_pkg::BYTE_BITS);
          wj_nxt       = j_new;
          acc_nxt      = acc_new;
        end
      end

      brr_pkg::S_DONE: begin
        res.valid = out_free;
        if (out_free) begin
          state_nxt = brr_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = brr_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/bit_reservoir_reader.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bit_reservoir_reader: circular byte store with an MSB-first bit reader
// Put, rewinds and rejected reads pass through the execute and done states into the
// output register; a read also takes one data step per stored byte, at most five for 32 bits.
// Items are handled one at a time, with one memory read per byte; the next item is
// accepted once the result is in the output register.
// Reset clears positions and counters; the byte store is never read before it is
// written, so it needs no clearing pass.
// ---------------------------------------------------------------------------
module bit_reservoir_reader (
  input  logic      clk,
  input  logic      rst_n,
  brr_in_if.sink    in_ch,
  brr_out_if.source out_ch
);

  // The sequencer drives one memory access per cycle: a write for a put,
  // or a read of the next byte a bit read needs. Read data is registered in
  // the store, and the sequencer consumes it in the cycle after the request.
  brr_pkg::mem_req_t mem_req;
  logic [7:0]        rd_data;

  // Finished results pass to the output register when it has room.
  brr_pkg::result_t  res;
  logic              out_free;

  brr_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // The sequencer holds write count, read position, bits left in the
  // current byte and the running total of consumed bits. A read checks
  // each byte index against the write count before fetching it, so an
  // underrun abandons the read with no state change.
  brr_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .mem_req  (mem_req),
    .rd_data  (rd_data),
    .out_free (out_free),
    .res      (res)
  );

  brr_outbuf u_outbuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for bit_reservoir_reader
// Drives put, get and rewind commands through the command channel. A
// predictor of the byte store and bit position computes each result, and a
// checker compares the results, field by field and in order, as they leave.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;

  // One expected result: the bits read, the running bit total and the error.
  typedef struct {
    logic [brr_pkg::WORD_W-1:0] value;
    logic [brr_pkg::WORD_W-1:0] consumed;
    brr_pkg::err_t              error;
  } reservoir_result_t;

  logic clk;
  logic rst_n;

  brr_in_if  in_ch ();
  brr_out_if out_ch ();

  bit_reservoir_reader DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted state of the block. The bit total doubles as the read position
  // in bits, since every completed read adds to it and every rewind takes from it.
  bit [7:0]                 rsv_bytes [brr_pkg::STORE_DEPTH];
  bit [brr_pkg::WORD_W-1:0] wr_cnt;
  bit [brr_pkg::WORD_W-1:0] rd_idx;
  int unsigned              bits_left;
  bit [brr_pkg::WORD_W-1:0] total_bits;

  reservoir_result_t pending_results[$];

  int errors;
  int items_sent;
  int results_seen;
  int underruns_seen;
  int too_long_seen;
  int cycle_cnt;
  int src_idle_pct;
  int sink_idle_pct;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bit_reservoir_reader test failed");
      $finish;
    end
  end

  // Works out the result of one accepted item and updates the predicted state.
  function automatic reservoir_result_t reservoir_predict(brr_pkg::cmd_t c, logic [7:0] d,
                                                          logic [brr_pkg::CNT_W-1:0] n);
    reservoir_result_t r;
    bit [brr_pkg::WORD_W-1:0] idx;
    bit [brr_pkg::WORD_W-1:0] acc;
    bit [brr_pkg::WORD_W-1:0] piece;
    bit [brr_pkg::WORD_W-1:0] pos;
    int unsigned              left;
    int unsigned              j;
    int unsigned              k;
    bit                       fail;
    r.value = '0;
    r.error = brr_pkg::ERR_NONE;
    case (c)
      brr_pkg::CMD_PUT: begin
        rsv_bytes[wr_cnt[brr_pkg::ADDR_W-1:0]] = d;
        wr_cnt++;
      end
      brr_pkg::CMD_GET: begin
        if (n > brr_pkg::MAX_READ_BITS) begin
          r.error = brr_pkg::ERR_TOO_LONG;
        end else begin
          idx  = rd_idx;
          left = bits_left;
          j    = n;
          acc  = '0;
          fail = 1'b0;
          while (j > 0 && !fail) begin
            // An exhausted byte is left behind only when the next bit is taken.
            if (left == 0) begin
              left = brr_pkg::BYTE_BITS;
              idx++;
            end
            if (idx >= wr_cnt) begin
              fail = 1'b1;
            end else begin
              k     = (j < left) ? j : left;
              piece = 32'(rsv_bytes[idx[brr_pkg::ADDR_W-1:0]]) & ((32'd1 << left) - 32'd1);
              piece = piece >> (left - k);
              acc   = acc | (piece << (j - k));
              left  = left - k;
              j     = j - k;
            end
          end
          if (fail) begin
            r.error = brr_pkg::ERR_UNDERRUN;
          end else begin
            r.value    = acc;
            rd_idx     = idx;
            bits_left  = left;
            total_bits = total_bits + n;
          end
        end
      end
      brr_pkg::CMD_REWIND_BITS: begin
        pos        = bits_left + n;
        total_bits = total_bits - n;
        rd_idx     = rd_idx - pos / brr_pkg::BYTE_BITS;
        bits_left  = pos % brr_pkg::BYTE_BITS;
      end
      default: begin
        total_bits = total_bits - (32'(n) << 3);
        rd_idx     = rd_idx - n;
      end
    endcase
    r.consumed = total_bits;
    return r;
  endfunction

  // Offers one item, holding valid across back-to-back items. Entered and left
  // at a falling edge.
  task automatic send_item(brr_pkg::cmd_t c, logic [7:0] d, logic [brr_pkg::CNT_W-1:0] n);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= c;
    in_ch.data_byte <= d;
    in_ch.count     <= n;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(reservoir_predict(c, d, n));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_byte(logic [7:0] d);
    send_item(brr_pkg::CMD_PUT, d, 12'($urandom_range(0, 4095)));
  endtask

  task automatic quiet_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // The receiver: random stalls, plus a long hold-off when one is asked for.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // Compares each result that leaves the block with the oldest prediction.
  always @(posedge clk) begin
    reservoir_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: value %h consumed %h error %0d",
                 $time, out_ch.read_value, out_ch.bits_consumed, out_ch.error);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.error == brr_pkg::ERR_UNDERRUN) underruns_seen++;
        if (exp_r.error == brr_pkg::ERR_TOO_LONG) too_long_seen++;
        if (out_ch.read_value !== exp_r.value) begin
          $display("%0t: read_value expected %h actual %h",
                   $time, exp_r.value, out_ch.read_value);
          errors++;
        end
        if (out_ch.bits_consumed !== exp_r.consumed) begin
          $display("%0t: bits_consumed expected %h actual %h",
                   $time, exp_r.consumed, out_ch.bits_consumed);
          errors++;
        end
        if (out_ch.error !== exp_r.error) begin
          $display("%0t: error expected %0d actual %0d",
                   $time, exp_r.error, out_ch.error);
          errors++;
        end
      end
    end
  end

  // Hand-picked items: empty store, too-long counts, byte boundaries, the lazy
  // advance into the next byte, a 32-bit read over five bytes and rewinds.
  task automatic test_directed();
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd0);
    send_item(brr_pkg::CMD_GET, 8'hFF, 12'd1);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd33);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd4095);
    send_item(brr_pkg::CMD_REWIND_BITS, 8'h00, 12'd0);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hA5);
    put_byte(8'h5A);
    put_byte(8'h3C);
    put_byte(8'hC3);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd3);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd5);
    // The first byte is used up; this read must step into the second one.
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd32);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd12);
    send_item(brr_pkg::CMD_REWIND_BITS, 8'h00, 12'd12);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd12);
    send_item(brr_pkg::CMD_REWIND_BYTES, 8'h00, 12'd3);
    put_byte(8'h81);
    put_byte(8'h7E);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd4);
    // Starts mid-byte, so 32 bits touch five stored bytes.
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd32);
    send_item(brr_pkg::CMD_REWIND_BITS, 8'h00, 12'd8);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd0);
  endtask

  // Mostly puts and reads that stay in step with each other, with rewinds that
  // never reach back past the first byte and some out-of-range reads.
  task automatic test_random(int n_items, int src_pct, int sink_pct);
    int          pick;
    int unsigned lim;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        send_item(brr_pkg::CMD_GET, 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, brr_pkg::MAX_READ_BITS)));
      end else if (pick < 80) begin
        send_item(brr_pkg::CMD_GET, 8'($urandom_range(0, 255)),
                  12'($urandom_range(brr_pkg::MAX_READ_BITS + 1, 4095)));
      end else if (pick < 90) begin
        lim = ($urandom_range(0, 9) == 0) ? 4095 : 64;
        lim = (total_bits < lim) ? total_bits : lim;
        send_item(brr_pkg::CMD_REWIND_BITS, 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, lim)));
      end else begin
        lim = ($urandom_range(0, 9) == 0) ? 511 : 6;
        lim = (total_bits / brr_pkg::BYTE_BITS < lim) ? total_bits / brr_pkg::BYTE_BITS : lim;
        send_item(brr_pkg::CMD_REWIND_BYTES, 8'($urandom_range(0, 255)),
                  12'($urandom_range(0, lim)));
      end
    end
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // block fills and has to hold off its input.
  task automatic test_backpressure();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_cycles   = 300;
    repeat (20) begin
      put_byte(8'($urandom_range(0, 255)));
      send_item(brr_pkg::CMD_GET, 8'h00, 12'($urandom_range(0, brr_pkg::MAX_READ_BITS)));
    end
  endtask

  // Rewinding further back than the first byte wraps the position, and every
  // read of one bit or more after that is an underrun, so this comes last.
  task automatic test_rewind_past_start();
    sink_idle_pct = 9;
    send_item(brr_pkg::CMD_REWIND_BYTES, 8'h00, 12'd4095);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd8);
    send_item(brr_pkg::CMD_REWIND_BITS, 8'h00, 12'd4095);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd0);
    put_byte(8'h55);
    send_item(brr_pkg::CMD_GET, 8'h00, 12'd32);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = brr_pkg::CMD_PUT;
    in_ch.data_byte = '0;
    in_ch.count     = '0;
    wr_cnt          = '0;
    rd_idx          = '0;
    bits_left       = brr_pkg::BYTE_BITS;
    total_bits      = '0;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    underruns_seen  = 0;
    too_long_seen   = 0;
    cycle_cnt       = 0;
    src_idle_pct    = 0;
    sink_idle_pct   = 0;
    hold_cycles     = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(230, 9, 76);
    test_random(230, 76, 9);
    test_random(240, 0, 0);
    test_backpressure();
    test_rewind_past_start();
    quiet_input();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items and checked %0d results, %0d underruns, %0d too-long reads,",
             items_sent, results_seen, underruns_seen, too_long_seen);
    $display("covering random stalls on both sides and a long output hold-off.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("bit_reservoir_reader test passed");
    end else begin
      $display("bit_reservoir_reader test failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/brr_pkg.sv
hdl/brr_if.sv
hdl/brr_store.sv
hdl/brr_outbuf.sv
hdl/brr_seq.sv
hdl/bit_reservoir_reader.sv
tb/testbench.sv
